>>> rtl/morse_state_beeper_assert.svh
// ----------------------------------------------------------------------------
// morse_state_beeper_assert.svh
// assertion macros used by the status beeper port checker
// ----------------------------------------------------------------------------
`ifndef MORSE_STATE_BEEPER_ASSERT_SVH
`define MORSE_STATE_BEEPER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define MSB_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("beeper check failed");

// next-cycle implication, clocked on clk, off during rst
`define MSB_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("beeper check failed");

`endif

>>> rtl/msb_pkg.sv
// ----------------------------------------------------------------------------
// msb_pkg
// types, constants and pattern tables of the morse status beeper
// ----------------------------------------------------------------------------
package msb_pkg;

  localparam int unsigned NUM_CODES    = 10;
  localparam int unsigned MAX_ELEMENTS = 6;
  localparam int unsigned CFG_ADDR_W   = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_DOT       = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_DASH      = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_GAP       = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_END_PAUSE = CFG_ADDR_W'(3);

  localparam logic [15:0] DOT_RESET       = 16'd20;
  localparam logic [15:0] DASH_RESET      = 16'd60;
  localparam logic [15:0] GAP_RESET       = 16'd20;
  localparam logic [15:0] END_PAUSE_RESET = 16'd40;

  // sequencer phases
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_TONE  = 3'd1;
  localparam logic [2:0] PH_GAP   = 3'd2;
  localparam logic [2:0] PH_END   = 3'd3;
  localparam logic [2:0] PH_WAIT  = 3'd4;

  // pattern length and dash mask, bit i set: element i is a dash
  localparam logic [3:0] PAT_LEN [16] = '{
    4'd3, 4'd2, 4'd4, 4'd4, 4'd4, 4'd2, 4'd3, 4'd2,
    4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6
  };
  localparam logic [7:0] PAT_DASH [16] = '{
    8'h00, 8'h00, 8'h06, 8'h01, 8'h05, 8'h02, 8'h01, 8'h03,
    8'h02, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A
  };

  typedef struct packed {
    logic [15:0] dot_ticks;
    logic [15:0] dash_ticks;
    logic [15:0] gap_ticks;
    logic [15:0] end_pause_ticks;
  } msb_cfg_t;

  function automatic logic [15:0] min_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [3:0] pattern_index(input logic [3:0] code);
    return (5'(code) < 5'(NUM_CODES)) ? code : 4'(NUM_CODES - 1);
  endfunction

  function automatic logic [3:0] pattern_length(input logic [3:0] idx);
    logic [3:0] len;
    len = PAT_LEN[idx];
    return (len > 4'(MAX_ELEMENTS)) ? 4'(MAX_ELEMENTS) : len;
  endfunction

  function automatic logic [15:0] element_ticks(input logic [3:0] idx,
                                                input logic [2:0] el,
                                                input msb_cfg_t cfg);
    logic is_dash;
    is_dash = PAT_DASH[idx][el];
    return min_one(is_dash ? cfg.dash_ticks : cfg.dot_ticks);
  endfunction

endpackage

>>> rtl/msb_in_if.sv
// ----------------------------------------------------------------------------
// msb_in_if
// tick request channel carrying the current state code
// ----------------------------------------------------------------------------
interface msb_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] state_code;

  modport source (output valid, output state_code, input ready);
  modport sink (input valid, input state_code, output ready);
endinterface

>>> rtl/msb_out_if.sv
// ----------------------------------------------------------------------------
// msb_out_if
// result channel with tone, playing flag and latched pattern index
// ----------------------------------------------------------------------------
interface msb_out_if;
  logic       valid;
  logic       ready;
  logic       tone_on;
  logic       playing;
  logic [3:0] latched_code;

  modport source (output valid, output tone_on, output playing, output latched_code,
                  input ready);
  modport sink (input valid, input tone_on, input playing, input latched_code,
                output ready);
endinterface

>>> rtl/msb_cfg_if.sv
// ----------------------------------------------------------------------------
// msb_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface msb_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  addr;
  logic [15:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

>>> rtl/msb_cfg_regs.sv
// ----------------------------------------------------------------------------
// msb_cfg_regs
// duration registers written over the configuration channel
// ----------------------------------------------------------------------------
module msb_cfg_regs import msb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  msb_cfg_if.sink   cfg,
  output msb_cfg_t  regs
);

  msb_cfg_t regs_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      unique case (cfg.addr)
        REG_DOT:       regs_next.dot_ticks       = cfg.data;
        REG_DASH:      regs_next.dash_ticks      = cfg.data;
        REG_GAP:       regs_next.gap_ticks       = cfg.data;
        REG_END_PAUSE: regs_next.end_pause_ticks = cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dot_ticks       <= DOT_RESET;
      regs.dash_ticks      <= DASH_RESET;
      regs.gap_ticks       <= GAP_RESET;
      regs.end_pause_ticks <= END_PAUSE_RESET;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

>>> rtl/msb_seq.sv
// ----------------------------------------------------------------------------
// msb_seq
// input register, pattern sequencer and result register
// ----------------------------------------------------------------------------
module msb_seq import msb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  msb_cfg_t   regs,
  msb_in_if.sink     item,
  msb_out_if.source  result
);

  logic        s1_valid;
  logic [3:0]  s1_code;
  logic        adv;

  logic [2:0]  phase, phase_next;
  logic [2:0]  element_index, element_index_next;
  logic [15:0] countdown, countdown_next;
  logic [3:0]  reported_code, reported_code_next;

  logic        latch;
  logic [3:0]  cur_code;
  logic [3:0]  idx;
  logic [2:0]  cur_phase;
  logic [2:0]  cur_el;
  logic [15:0] cur_cnt;
  logic [15:0] dec;
  logic        tone, play;

  assign adv        = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || adv;

  always_comb begin
    latch     = (phase == PH_START) || ((phase == PH_WAIT) && (s1_code != reported_code));
    cur_code  = latch ? s1_code : reported_code;
    idx       = pattern_index(cur_code);
    cur_phase = latch ? PH_TONE : phase;
    cur_el    = latch ? 3'd0 : element_index;
    cur_cnt   = latch ? element_ticks(idx, 3'd0, regs) : countdown;
    dec       = cur_cnt - 16'd1;

    phase_next         = cur_phase;
    element_index_next = cur_el;
    countdown_next     = cur_cnt;
    reported_code_next = cur_code;
    tone               = 1'b0;
    play               = 1'b0;

    unique case (cur_phase)
      PH_TONE: begin
        tone           = 1'b1;
        play           = 1'b1;
        countdown_next = dec;
        if (dec == 16'd0) begin
          phase_next     = PH_GAP;
          countdown_next = min_one(regs.gap_ticks);
        end
      end
      PH_GAP: begin
        play           = 1'b1;
        countdown_next = dec;
        if (dec == 16'd0) begin
          if (({1'b0, cur_el} + 4'd1) < pattern_length(idx)) begin
            element_index_next = cur_el + 3'd1;
            phase_next         = PH_TONE;
            countdown_next     = element_ticks(idx, cur_el + 3'd1, regs);
          end else begin
            phase_next     = PH_END;
            countdown_next = min_one(regs.end_pause_ticks);
          end
        end
      end
      PH_END: begin
        play           = 1'b1;
        countdown_next = dec;
        if (dec == 16'd0) begin
          phase_next = PH_WAIT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      result.valid  <= 1'b0;
      phase         <= PH_START;
      element_index <= 3'd0;
      countdown     <= 16'd0;
      reported_code <= 4'd0;
    end else begin
      if (item.valid && item.ready) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        result.valid  <= 1'b1;
        phase         <= phase_next;
        element_index <= element_index_next;
        countdown     <= countdown_next;
        reported_code <= reported_code_next;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_code <= item.state_code;
    end
    if (adv) begin
      result.tone_on      <= tone;
      result.playing      <= play;
      result.latched_code <= idx;
    end
  end

endmodule

>>> rtl/morse_state_beeper.sv
// an accepted tick request passes the input register, then the result register
// throughput: one tick per cycle unless results stall; sequencer update is one
//   countdown decrement and a pattern table lookup between two registers
// reset (rst, synchronous): pipeline empty, durations 20/60/20/40 ticks,
//   the first tick after reset latches its code and starts the pattern
// ----------------------------------------------------------------------------
// morse_state_beeper
// sounds the current state code as a morse pattern, one result per tick
// ----------------------------------------------------------------------------
module morse_state_beeper import msb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  msb_in_if.sink     item,
  msb_out_if.source  result,
  msb_cfg_if.sink    cfg
);

  msb_cfg_t regs;

  msb_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  msb_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .item   (item),
    .result (result)
  );

endmodule

>>> rtl/morse_state_beeper_chk.sv
// ----------------------------------------------------------------------------
// morse_state_beeper_chk
// port-level checks of the status beeper, bound to the top level
// ----------------------------------------------------------------------------
`include "morse_state_beeper_assert.svh"

module morse_state_beeper_chk import msb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic       tone_on,
  input logic       playing,
  input logic [3:0] latched_code
);

  logic [2:0] pend;
  logic       in_acc, out_acc;

  assign in_acc  = item_valid && item_ready;
  assign out_acc = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 3'd0;
    end else begin
      pend <= pend + 3'(in_acc) - 3'(out_acc);
    end
  end

  `MSB_AST_NOW(a_tone_while_playing, result_valid && tone_on, playing)
  `MSB_AST_NOW(a_code_in_range, result_valid, 5'(latched_code) < 5'(NUM_CODES))
  `MSB_AST_NOW(a_no_spurious_result, result_valid, (pend != 3'd0) && (pend <= 3'd2))
  `MSB_AST_NEXT(a_stall_holds, result_valid && !result_ready,
                result_valid && $stable(tone_on) && $stable(playing) &&
                $stable(latched_code))

endmodule

bind morse_state_beeper morse_state_beeper_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .tone_on      (result.tone_on),
  .playing      (result.playing),
  .latched_code (result.latched_code)
);

>>> dv/beeper_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// beeper_checker
// watches the tick, result and register channels of the morse status
// beeper, runs its own copy of the pattern sequencer on every accepted tick
// request and compares each accepted result with the oldest prediction
// ----------------------------------------------------------------------------
module beeper_checker import msb_pkg::*; (
  input  logic clk,
  input  logic rst,
  msb_in_if    item,
  msb_out_if   result,
  msb_cfg_if   cfg,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic       tone_on;
    logic       playing;
    logic [3:0] latched_code;
  } tick_result_t;

  msb_cfg_t     durations;
  logic [3:0]   held_code;
  logic [2:0]   seq_phase;
  logic [2:0]   elem;
  logic [15:0]  remaining;
  tick_result_t expected_ticks [$];
  tick_result_t predicted;
  tick_result_t observed;
  tick_result_t oldest;
  int           errors;

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [3:0] pattern_of(input logic [3:0] code);
    if (int'(code) < int'(NUM_CODES)) return code;
    return 4'(NUM_CODES - 1);
  endfunction

  function automatic logic [15:0] tone_length(input logic [3:0] pat, input logic [2:0] el);
    return at_least_one(PAT_DASH[pat][el] ? durations.dash_ticks : durations.dot_ticks);
  endfunction

  task automatic predict_tick(input logic [3:0] code, output tick_result_t r);
    logic [3:0] pat;
    int         n_elem;
    r = '0;
    if (seq_phase == PH_START || (seq_phase == PH_WAIT && code != held_code)) begin
      held_code = code;
      elem      = 3'd0;
      seq_phase = PH_TONE;
      remaining = tone_length(pattern_of(code), 3'd0);
    end
    pat = pattern_of(held_code);
    n_elem = (int'(PAT_LEN[pat]) > int'(MAX_ELEMENTS)) ? int'(MAX_ELEMENTS)
                                                       : int'(PAT_LEN[pat]);
    r.latched_code = pat;
    case (seq_phase)
      PH_TONE: begin
        r.tone_on = 1'b1;
        r.playing = 1'b1;
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) begin
          seq_phase = PH_GAP;
          remaining = at_least_one(durations.gap_ticks);
        end
      end
      PH_GAP: begin
        r.playing = 1'b1;
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) begin
          if (int'(elem) + 1 < n_elem) begin
            elem      = elem + 3'd1;
            seq_phase = PH_TONE;
            remaining = tone_length(pat, elem);
          end else begin
            seq_phase = PH_END;
            remaining = at_least_one(durations.end_pause_ticks);
          end
        end
      end
      PH_END: begin
        r.playing = 1'b1;
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) seq_phase = PH_WAIT;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      durations = '{DOT_RESET, DASH_RESET, GAP_RESET, END_PAUSE_RESET};
      held_code = 4'd0;
      seq_phase = PH_START;
      elem      = 3'd0;
      remaining = 16'd0;
      expected_ticks.delete();
      errors    = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          REG_DOT:       durations.dot_ticks       = cfg.data;
          REG_DASH:      durations.dash_ticks      = cfg.data;
          REG_GAP:       durations.gap_ticks       = cfg.data;
          REG_END_PAUSE: durations.end_pause_ticks = cfg.data;
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        predict_tick(item.state_code, predicted);
        expected_ticks.push_back(predicted);
      end
      if (result.valid && result.ready) begin
        observed = '{result.tone_on, result.playing, result.latched_code};
        if (expected_ticks.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, got tone=%0b playing=%0b code=%0d",
                   $time, observed.tone_on, observed.playing, observed.latched_code);
        end else begin
          oldest = expected_ticks.pop_front();
          if (observed.tone_on !== oldest.tone_on || observed.playing !== oldest.playing ||
              observed.latched_code !== oldest.latched_code) begin
            errors++;
            $display("%0t mismatch: exp tone=%0b playing=%0b code=%0d, got %0b %0b %0d",
                     $time, oldest.tone_on, oldest.playing, oldest.latched_code,
                     observed.tone_on, observed.playing, observed.latched_code);
          end
        end
      end
    end
    fail_count  <= errors;
    outstanding <= expected_ticks.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives the morse status beeper with a short directed run and then random
// state code ticks under several duration settings and idling mixes; the
// checker predicts every result, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_top;
  import msb_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic       clk;
  logic       rst;
  int         send_pct  = 0;
  int         stall_pct = 0;
  int         mismatches;
  int         outstanding;
  int         quiet_cycles = 0;
  int         k;
  logic [3:0] cur_code = 4'd0;
  logic [3:0] opening_codes [0:24] = '{
    4'd0, 4'd0, 4'd0, 4'd15, 4'd15, 4'd9, 4'd10, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
    4'd7, 4'd8, 4'd11, 4'd12, 4'd13, 4'd14, 4'd0, 4'd15, 4'd0, 4'd10, 4'd15, 4'd9
  };

  msb_in_if  item ();
  msb_out_if result ();
  msb_cfg_if cfg ();

  morse_state_beeper dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  beeper_checker chk (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .cfg         (cfg),
    .fail_count  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stalls
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // held code with rare changes, jumps to invalid codes and one-tick glitches
  function automatic logic [3:0] next_code();
    int r;
    r = $urandom_range(99);
    if (r < 4) cur_code = 4'($urandom_range(15));
    else if (r < 6) cur_code = 4'($urandom_range(15, NUM_CODES));
    return (r == 99) ? 4'($urandom_range(15)) : cur_code;
  endfunction

  task automatic send_tick(input logic [3:0] code);
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      item.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    item.valid      <= 1'b1;
    item.state_code <= code;
    do @(posedge clk); while (item.ready !== 1'b1);
  endtask

  task automatic wait_results_done();
    item.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [15:0] data);
    cfg.valid <= 1'b1;
    cfg.addr  <= addr;
    cfg.data  <= data;
    do @(posedge clk); while (cfg.ready !== 1'b1);
  endtask

  task automatic set_durations(input logic [15:0] dot, input logic [15:0] dash,
                               input logic [15:0] gap, input logic [15:0] pause);
    wait_results_done();
    write_reg(REG_DOT, dot);
    write_reg(REG_DASH, dash);
    write_reg(REG_GAP, gap);
    // unmapped index, must be ignored
    write_reg(REG_END_PAUSE + 4'($urandom_range(12, 1)), 16'($urandom_range(65535)));
    write_reg(REG_END_PAUSE, pause);
    cfg.valid <= 1'b0;
  endtask

  task automatic run_ticks(input int n, input int mode, input int pause_at);
    int i;
    case (mode)
      1:       begin send_pct = 67; stall_pct = 0;  end
      2:       begin send_pct = 0;  stall_pct = 67; end
      3:       begin send_pct = 35; stall_pct = 35; end
      default: begin send_pct = 0;  stall_pct = 0;  end
    endcase
    for (i = 0; i < n; i++) begin
      if (i == pause_at) wait_results_done();
      send_tick(next_code());
    end
  endtask

  initial begin
    rst             <= 1'b1;
    item.valid      <= 1'b0;
    item.state_code <= 4'd0;
    cfg.valid       <= 1'b0;
    cfg.addr        <= 4'd0;
    cfg.data        <= 16'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset durations, code changes while the first pattern plays
    foreach (opening_codes[k]) send_tick(opening_codes[k]);

    // zero durations act as one
    set_durations(16'd0, 16'd0, 16'd0, 16'd0);
    run_ticks(150, 1, -1);
    set_durations(16'd1, 16'd1, 16'd1, 16'd1);
    run_ticks(150, 2, -1);

    for (k = 0; k < 4; k++) begin
      set_durations(16'($urandom_range(6)), 16'($urandom_range(6)),
                    16'($urandom_range(6)), 16'($urandom_range(6)));
      run_ticks(150, (k + 3) % 4, (k == 0) ? 75 : -1);
    end

    set_durations(16'($urandom_range(40, 1)), 16'($urandom_range(40, 1)),
                  16'($urandom_range(40, 1)), 16'($urandom_range(40, 1)));
    run_ticks(300, 3, -1);

    // longest durations, with a changed held code
    set_durations(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    cur_code = ~cur_code;
    run_ticks(30, 0, -1);

    wait_results_done();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/msb_pkg.sv
rtl/msb_in_if.sv
rtl/msb_out_if.sv
rtl/msb_cfg_if.sv
rtl/msb_cfg_regs.sv
rtl/msb_seq.sv
rtl/morse_state_beeper.sv
rtl/morse_state_beeper_chk.sv
dv/beeper_checker.sv
dv/tb_top.sv
